// ===== rtl/ssd_pkg.sv =====
// ============================================================================
// ssd_pkg
// Shared widths, types and arithmetic helpers for the segment distance block.
// ============================================================================
package ssd_pkg;

    // Field widths of the channels and the configuration register.
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int DIR_W       = 18;
    localparam int LIMIT_W     = 16;
    localparam int LIMIT_SHIFT = 16;
    localparam int OUT_W       = COORD_W + 1;

    // Internal widths: coordinate differences, products and sums of squares.
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = PROD_W - 1;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int DC_W   = 2 * DIR_W + 1;

    // Stage counts of the iterative units: one result bit per stage, after the divider's overflow stage.
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = OUT_W + 1;

    // Number of perpendicular candidates (two endpoints onto each segment).
    localparam int NUM_PERP = 4;
    localparam int NUM_SQRT = 6;

    // Flags that ride alongside the square root and divide pipelines.
    typedef struct packed {
        logic                crossing;
        logic [NUM_PERP-1:0] perp_ok;
    } side_t;

    // Signed product of two coordinate differences.
    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

    // Magnitude of a signed sum; the sums stay below 2^SQ_W in magnitude.
    function automatic logic [SQ_W-1:0] mag(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] n;
        n = -v;
        return v[PROD_W-1] ? n[SQ_W-1:0] : v[SQ_W-1:0];
    endfunction

endpackage

// ===== rtl/ssd_pair_if.sv =====
// ============================================================================
// ssd_pair_if
// Input channel: two segments with their unit directions.
// ============================================================================
interface ssd_pair_if;

    logic                                valid;
    logic                                ready;
    logic signed [ssd_pkg::COORD_W-1:0] a_x;
    logic signed [ssd_pkg::COORD_W-1:0] a_y;
    logic signed [ssd_pkg::COORD_W-1:0] b_x;
    logic signed [ssd_pkg::COORD_W-1:0] b_y;
    logic signed [ssd_pkg::COORD_W-1:0] c_x;
    logic signed [ssd_pkg::COORD_W-1:0] c_y;
    logic signed [ssd_pkg::COORD_W-1:0] d_x;
    logic signed [ssd_pkg::COORD_W-1:0] d_y;
    logic signed [ssd_pkg::DIR_W-1:0]   first_dir_x;
    logic signed [ssd_pkg::DIR_W-1:0]   first_dir_y;
    logic signed [ssd_pkg::DIR_W-1:0]   second_dir_x;
    logic signed [ssd_pkg::DIR_W-1:0]   second_dir_y;

    modport source (
        output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
               first_dir_x, first_dir_y, second_dir_x, second_dir_y,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
               first_dir_x, first_dir_y, second_dir_x, second_dir_y,
        output ready
    );

endinterface

// ===== rtl/ssd_dist_if.sv =====
// ============================================================================
// ssd_dist_if
// Output channel: segment distance and crossing flag.
// ============================================================================
interface ssd_dist_if;

    logic                       valid;
    logic                       ready;
    logic [ssd_pkg::OUT_W-1:0] seg_distance;
    logic                       crossing;

    modport source (
        output valid, seg_distance, crossing,
        input  ready
    );

    modport sink (
        input  valid, seg_distance, crossing,
        output ready
    );

endinterface

// ===== rtl/ssd_sqrt.sv =====
// ============================================================================
// ssd_sqrt
// Pipelined integer square root, floor(sqrt(v)), one root bit per stage.
// ============================================================================
module ssd_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ssd_pkg::SQ_W-1:0]    v,
    output logic [ssd_pkg::ROOT_W-1:0]  root
);

    localparam int RW = ssd_pkg::SQ_W + 2;
    localparam int NB = ssd_pkg::ROOT_W;

    // Remainder v - root^2 and the partial root at each stage.
    logic [RW-1:0] rem_reg  [0:NB-2];
    logic [NB-1:0] root_reg [0:NB-1];

    for (genvar s = 0; s < NB; s++)
    begin : g_step
        localparam int B = NB - 1 - s;
        logic [RW-1:0] rem_in;
        logic [RW-1:0] trial;
        logic [NB-1:0] root_in;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in  = RW'(v);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
        assign trial = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= take ? (root_in | (NB'(1) << B)) : root_in;
            end
        end

        if (s < NB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[NB-1];

endmodule

// ===== rtl/ssd_div.sv =====
// ============================================================================
// ssd_div
// Pipelined restoring divider with a saturating quotient, one bit per stage.
// ============================================================================
module ssd_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ssd_pkg::SQ_W-1:0]    num,
    input  logic [ssd_pkg::ROOT_W-1:0]  den,
    output logic [ssd_pkg::OUT_W-1:0]   quo
);

    localparam int DW = ssd_pkg::SQ_W + 2;
    localparam int QW = ssd_pkg::OUT_W;

    logic [DW-1:0]                   rem_reg [0:QW-1];
    logic [ssd_pkg::ROOT_W-1:0]      den_reg [0:QW-1];
    logic [QW-1:0]                   quo_reg [1:QW];
    logic                            ovf_reg [0:QW];

    // First stage: a quotient that needs more than QW bits saturates.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num);
            den_reg[0] <= den;
            ovf_reg[0] <= (DW'(num) >= (DW'(den) << QW));
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        localparam int B = QW - 1 - s;
        logic [DW-1:0] sub;
        logic [QW-1:0] quo_in;
        logic          take;

        if (s == 0)
        begin : g_first
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign quo_in = quo_reg[s];
        end

        assign sub  = DW'(den_reg[s]) << B;
        assign take = (rem_reg[s] >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s+1] <= take ? (quo_in | (QW'(1) << B)) : quo_in;
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end

        if (s < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= take ? (rem_reg[s] - sub) : rem_reg[s];
                    den_reg[s+1] <= den_reg[s];
                end
            end
        end
    end

    assign quo = ovf_reg[QW] ? '1 : quo_reg[QW];

endmodule

// ===== rtl/segment_segment_distance.sv =====
// ============================================================================
// segment_segment_distance
// Minimum distance between two 2D segments with a crossing flag, pipelined.
// ============================================================================
//
//  Channel    Direction  Handshake            Contents
//  pair_in    in         valid / ready        segments AB, CD and unit directions
//  dist_out   out        valid / ready        seg_distance, crossing
//  cfg        in         cfg_we / cfg_wdata   parallel_limit
//
//  A pair can enter every cycle in which no result waits in the output
//  register. The pipeline has three stages of differences, products and
//  sums, 33 square root stages, 34 divider stages and the output register.
//  The whole pipeline advances together and holds while a result waits in
//  the output register, so a stall loses and repeats nothing.
//  Reset clears the valid bits and sets parallel_limit to zero.
//
module segment_segment_distance (
    input  logic                          clk,
    input  logic                          rst_n,
    ssd_pair_if.sink                      pair_in,
    ssd_dist_if.source                    dist_out,
    input  logic                          cfg_we,
    input  logic [ssd_pkg::LIMIT_W-1:0]  cfg_wdata
);

    localparam int SQ  = ssd_pkg::SQRT_STAGES;
    localparam int DV  = ssd_pkg::DIV_STAGES;
    localparam int LAT = SQ + DV;
    localparam int DW  = ssd_pkg::DIFF_W;
    localparam int PW  = ssd_pkg::PROD_W;
    localparam int SW  = ssd_pkg::SQ_W;
    localparam int RW  = ssd_pkg::ROOT_W;
    localparam int OW  = ssd_pkg::OUT_W;
    localparam int CW  = ssd_pkg::DC_W;
    localparam int NP  = ssd_pkg::NUM_PERP;

    // Parameter in [0,1] test on n/det, done by sign and magnitude.
    function automatic logic in_unit(
        input logic signed [PW-1:0] n,
        input logic signed [PW-1:0] det
    );
        if (!det[PW-1])
        begin
            return !n[PW-1] && (n <= det);
        end
        return (n[PW-1] || (n == '0)) && (n >= det);
    endfunction

    // Projection of the point lands between the segment's ends.
    function automatic logic foot_on(
        input logic signed [PW-1:0] dt,
        input logic        [SW-1:0] l2
    );
        return (l2 != '0) && !dt[PW-1] && (dt <= $signed({1'b0, l2}));
    endfunction

    logic en;
    logic [ssd_pkg::LIMIT_W-1:0] limit_reg;

    logic [2:0]     vld_reg;
    logic [LAT-1:0] vld_dly_reg;
    logic           out_valid_reg;

    // The pipeline moves unless a finished result is still waiting.
    assign en            = !out_valid_reg || dist_out.ready;
    assign pair_in.ready = en;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            vld_dly_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[1:0], pair_in.valid};
            vld_dly_reg   <= {vld_dly_reg[LAT-2:0], vld_reg[2]};
            out_valid_reg <= vld_dly_reg[LAT-1];
        end
    end

    // Stage 1: coordinate differences and the direction products.
    logic signed [DW-1:0] abx_reg, aby_reg, cdx_reg, cdy_reg;
    logic signed [DW-1:0] acx_reg, acy_reg, adx_reg, ady_reg;
    logic signed [DW-1:0] bcx_reg, bcy_reg, bdx_reg, bdy_reg;
    logic signed [2*ssd_pkg::DIR_W-1:0] dc1_reg, dc2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx_reg <= DW'(pair_in.b_x) - DW'(pair_in.a_x);
            aby_reg <= DW'(pair_in.b_y) - DW'(pair_in.a_y);
            cdx_reg <= DW'(pair_in.d_x) - DW'(pair_in.c_x);
            cdy_reg <= DW'(pair_in.d_y) - DW'(pair_in.c_y);
            acx_reg <= DW'(pair_in.c_x) - DW'(pair_in.a_x);
            acy_reg <= DW'(pair_in.c_y) - DW'(pair_in.a_y);
            adx_reg <= DW'(pair_in.d_x) - DW'(pair_in.a_x);
            ady_reg <= DW'(pair_in.d_y) - DW'(pair_in.a_y);
            bcx_reg <= DW'(pair_in.c_x) - DW'(pair_in.b_x);
            bcy_reg <= DW'(pair_in.c_y) - DW'(pair_in.b_y);
            bdx_reg <= DW'(pair_in.d_x) - DW'(pair_in.b_x);
            bdy_reg <= DW'(pair_in.d_y) - DW'(pair_in.b_y);
            dc1_reg <= (2*ssd_pkg::DIR_W)'(pair_in.first_dir_x)
                     * (2*ssd_pkg::DIR_W)'(pair_in.second_dir_y);
            dc2_reg <= (2*ssd_pkg::DIR_W)'(pair_in.first_dir_y)
                     * (2*ssd_pkg::DIR_W)'(pair_in.second_dir_x);
        end
    end

    // Stage 2: all products of differences, and the parallel test.
    logic signed [PW-1:0] p_aby_cdx_reg, p_abx_cdy_reg, p_acy_cdx_reg, p_acx_cdy_reg;
    logic signed [PW-1:0] p_abx_acy_reg, p_aby_acx_reg, p_abx_ady_reg, p_aby_adx_reg;
    logic signed [PW-1:0] p_acx_abx_reg, p_acy_aby_reg, p_adx_abx_reg, p_ady_aby_reg;
    logic signed [PW-1:0] p_acx_cdx_reg, p_acy_cdy_reg, p_bcx_cdx_reg, p_bcy_cdy_reg;
    logic signed [PW-1:0] p_bcx_cdy_reg, p_bcy_cdx_reg;
    logic signed [PW-1:0] q_acx_reg, q_acy_reg, q_adx_reg, q_ady_reg;
    logic signed [PW-1:0] q_bcx_reg, q_bcy_reg, q_bdx_reg, q_bdy_reg;
    logic signed [PW-1:0] q_abx_reg, q_aby_reg, q_cdx_reg, q_cdy_reg;
    logic                 nonpar2_reg;

    logic signed [CW-1:0] dc_next;
    logic        [CW-1:0] dc_abs;

    assign dc_next = CW'(dc1_reg) - CW'(dc2_reg);
    assign dc_abs  = dc_next[CW-1] ? CW'(-dc_next) : CW'(dc_next);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_aby_cdx_reg <= ssd_pkg::smul(aby_reg, cdx_reg);
            p_abx_cdy_reg <= ssd_pkg::smul(abx_reg, cdy_reg);
            p_acy_cdx_reg <= ssd_pkg::smul(acy_reg, cdx_reg);
            p_acx_cdy_reg <= ssd_pkg::smul(acx_reg, cdy_reg);
            p_abx_acy_reg <= ssd_pkg::smul(abx_reg, acy_reg);
            p_aby_acx_reg <= ssd_pkg::smul(aby_reg, acx_reg);
            p_abx_ady_reg <= ssd_pkg::smul(abx_reg, ady_reg);
            p_aby_adx_reg <= ssd_pkg::smul(aby_reg, adx_reg);
            p_acx_abx_reg <= ssd_pkg::smul(acx_reg, abx_reg);
            p_acy_aby_reg <= ssd_pkg::smul(acy_reg, aby_reg);
            p_adx_abx_reg <= ssd_pkg::smul(adx_reg, abx_reg);
            p_ady_aby_reg <= ssd_pkg::smul(ady_reg, aby_reg);
            p_acx_cdx_reg <= ssd_pkg::smul(acx_reg, cdx_reg);
            p_acy_cdy_reg <= ssd_pkg::smul(acy_reg, cdy_reg);
            p_bcx_cdx_reg <= ssd_pkg::smul(bcx_reg, cdx_reg);
            p_bcy_cdy_reg <= ssd_pkg::smul(bcy_reg, cdy_reg);
            p_bcx_cdy_reg <= ssd_pkg::smul(bcx_reg, cdy_reg);
            p_bcy_cdx_reg <= ssd_pkg::smul(bcy_reg, cdx_reg);
            q_acx_reg     <= ssd_pkg::smul(acx_reg, acx_reg);
            q_acy_reg     <= ssd_pkg::smul(acy_reg, acy_reg);
            q_adx_reg     <= ssd_pkg::smul(adx_reg, adx_reg);
            q_ady_reg     <= ssd_pkg::smul(ady_reg, ady_reg);
            q_bcx_reg     <= ssd_pkg::smul(bcx_reg, bcx_reg);
            q_bcy_reg     <= ssd_pkg::smul(bcy_reg, bcy_reg);
            q_bdx_reg     <= ssd_pkg::smul(bdx_reg, bdx_reg);
            q_bdy_reg     <= ssd_pkg::smul(bdy_reg, bdy_reg);
            q_abx_reg     <= ssd_pkg::smul(abx_reg, abx_reg);
            q_aby_reg     <= ssd_pkg::smul(aby_reg, aby_reg);
            q_cdx_reg     <= ssd_pkg::smul(cdx_reg, cdx_reg);
            q_cdy_reg     <= ssd_pkg::smul(cdy_reg, cdy_reg);
            nonpar2_reg   <= dc_abs > (CW'(limit_reg) << ssd_pkg::LIMIT_SHIFT);
        end
    end

    // Stage 3: determinants, dot products, squared lengths.
    logic signed [PW-1:0] det_reg, nt_reg, nu_reg, cr2_reg, cr4_reg;
    logic signed [PW-1:0] dt1_reg, dt2_reg, dt3_reg, dt4_reg;
    logic        [SW-1:0] e_ac_reg, e_ad_reg, e_bc_reg, e_bd_reg, l2ab_reg, l2cd_reg;
    logic                 nonpar3_reg;
    logic signed [PW-1:0] e_ac_next, e_ad_next, e_bc_next, e_bd_next;
    logic signed [PW-1:0] l2ab_next, l2cd_next;

    assign e_ac_next = q_acx_reg + q_acy_reg;
    assign e_ad_next = q_adx_reg + q_ady_reg;
    assign e_bc_next = q_bcx_reg + q_bcy_reg;
    assign e_bd_next = q_bdx_reg + q_bdy_reg;
    assign l2ab_next = q_abx_reg + q_aby_reg;
    assign l2cd_next = q_cdx_reg + q_cdy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg     <= p_aby_cdx_reg - p_abx_cdy_reg;
            nt_reg      <= p_acy_cdx_reg - p_acx_cdy_reg;
            nu_reg      <= p_abx_acy_reg - p_aby_acx_reg;
            cr2_reg     <= p_abx_ady_reg - p_aby_adx_reg;
            cr4_reg     <= p_bcx_cdy_reg - p_bcy_cdx_reg;
            dt1_reg     <= p_acx_abx_reg + p_acy_aby_reg;
            dt2_reg     <= p_adx_abx_reg + p_ady_aby_reg;
            dt3_reg     <= -(p_acx_cdx_reg + p_acy_cdy_reg);
            dt4_reg     <= -(p_bcx_cdx_reg + p_bcy_cdy_reg);
            e_ac_reg    <= e_ac_next[SW-1:0];
            e_ad_reg    <= e_ad_next[SW-1:0];
            e_bc_reg    <= e_bc_next[SW-1:0];
            e_bd_reg    <= e_bd_next[SW-1:0];
            l2ab_reg    <= l2ab_next[SW-1:0];
            l2cd_reg    <= l2cd_next[SW-1:0];
            nonpar3_reg <= nonpar2_reg;
        end
    end

    // Crossing and projection flags, carried to the end of the pipeline.
    ssd_pkg::side_t side_next;
    ssd_pkg::side_t side_dly_reg [0:LAT-1];
    logic [NP-1:0][SW-1:0] mag_next;
    logic [NP-1:0][SW-1:0] mag_dly_reg [0:SQ-1];

    always_comb
    begin
        side_next.crossing = nonpar3_reg && (det_reg != '0)
                           && in_unit(nt_reg, det_reg) && in_unit(nu_reg, det_reg);
        side_next.perp_ok  = {foot_on(dt4_reg, l2cd_reg), foot_on(dt3_reg, l2cd_reg),
                              foot_on(dt2_reg, l2ab_reg), foot_on(dt1_reg, l2ab_reg)};
        mag_next           = {ssd_pkg::mag(cr4_reg), ssd_pkg::mag(nt_reg),
                              ssd_pkg::mag(cr2_reg), ssd_pkg::mag(nu_reg)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dly_reg[0] <= side_next;
            for (int i = 1; i < LAT; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
            mag_dly_reg[0] <= mag_next;
            for (int i = 1; i < SQ; i++)
            begin
                mag_dly_reg[i] <= mag_dly_reg[i-1];
            end
        end
    end

    // Square roots of the four endpoint distances and two segment lengths.
    logic [SW-1:0] sq_in   [ssd_pkg::NUM_SQRT];
    logic [RW-1:0] sq_root [ssd_pkg::NUM_SQRT];

    assign sq_in[0] = e_ac_reg;
    assign sq_in[1] = e_ad_reg;
    assign sq_in[2] = e_bc_reg;
    assign sq_in[3] = e_bd_reg;
    assign sq_in[4] = l2ab_reg;
    assign sq_in[5] = l2cd_reg;

    for (genvar k = 0; k < ssd_pkg::NUM_SQRT; k++)
    begin : g_sqrt
        ssd_sqrt u_sqrt (
            .clk  (clk),
            .en   (en),
            .v    (sq_in[k]),
            .root (sq_root[k])
        );
    end

    // Closest endpoint pair, held while the divides run.
    logic [OW-1:0] ep_min;
    logic [OW-1:0] ep_dly_reg [0:DV-1];

    always_comb
    begin
        ep_min = OW'(sq_root[0]);
        for (int k = 1; k < 4; k++)
        begin
            if (OW'(sq_root[k]) < ep_min)
            begin
                ep_min = OW'(sq_root[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ep_dly_reg[0] <= ep_min;
            for (int i = 1; i < DV; i++)
            begin
                ep_dly_reg[i] <= ep_dly_reg[i-1];
            end
        end
    end

    // Perpendicular distances: |cross| / floor(sqrt(L)).
    logic [OW-1:0] perp_q [NP];

    for (genvar k = 0; k < NP; k++)
    begin : g_div
        ssd_div u_div (
            .clk (clk),
            .en  (en),
            .num (mag_dly_reg[SQ-1][k]),
            .den (sq_root[4 + k / 2]),
            .quo (perp_q[k])
        );
    end

    // Output stage: pick the smallest candidate, or zero on a crossing.
    logic [OW-1:0]  best;
    ssd_pkg::side_t side_end;
    logic [OW-1:0]  dist_reg;
    logic           cross_reg;

    assign side_end = side_dly_reg[LAT-1];

    always_comb
    begin
        best = ep_dly_reg[DV-1];
        for (int k = 0; k < NP; k++)
        begin
            if (side_end.perp_ok[k] && (perp_q[k] < best))
            begin
                best = perp_q[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg  <= side_end.crossing ? '0 : best;
            cross_reg <= side_end.crossing;
        end
    end

    assign dist_out.valid        = out_valid_reg;
    assign dist_out.seg_distance = dist_reg;
    assign dist_out.crossing     = cross_reg;

endmodule

// ===== test/segment_distance_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// segment_distance_checker
// Watches both channels of the segment distance block, computes the expected
// distance and crossing flag for every accepted pair, and compares them in
// order with the results that the block delivers.
// ============================================================================
module segment_distance_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    ssd_pair_if                           pair_in,
    ssd_dist_if                           dist_out,
    input  logic                          cfg_we,
    input  logic [ssd_pkg::LIMIT_W-1:0]  cfg_wdata,
    output int                            error_count,
    output int                            pending_count
);
    import ssd_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] seg_distance;
        logic             crossing;
    } dist_result_t;

    localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

    // Expected results in arrival order; far more slots than the pipeline holds.
    localparam int EXP_DEPTH = 256;

    dist_result_t             expected_dists [0:EXP_DEPTH-1];
    int                       wr_total;
    int                       rd_total;
    logic [LIMIT_W-1:0]       limit_copy;

    // Integer square root, floor, of a nonnegative value.
    function automatic logic [63:0] int_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] clip(input logic [127:0] v);
        return (v > {95'd0, DIST_MAX}) ? DIST_MAX : v[OUT_W-1:0];
    endfunction

    function automatic logic signed [127:0] cross_of(
        input logic signed [127:0] ux, input logic signed [127:0] uy,
        input logic signed [127:0] vx, input logic signed [127:0] vy);
        return ux * vy - uy * vx;
    endfunction

    // Ratio n/d in [0,1], tested by sign and magnitude.
    function automatic bit in_range(input logic signed [127:0] n,
                                    input logic signed [127:0] d);
        if (d >= 0)
            return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    // Perpendicular candidate of offset p relative to U on segment u.
    function automatic logic [OUT_W-1:0] foot_dist(
        input logic [OUT_W-1:0] best,
        input logic signed [127:0] ux, input logic signed [127:0] uy,
        input logic signed [127:0] l2, input logic [63:0] root,
        input logic signed [127:0] px, input logic signed [127:0] py);
        logic signed [127:0] dt;
        logic signed [127:0] cr;
        logic [OUT_W-1:0]    c;
        dt = px * ux + py * uy;
        if (dt >= 0 && dt <= l2)
        begin
            cr = cross_of(ux, uy, px, py);
            if (cr < 0)
                cr = -cr;
            c = clip(cr / $signed({64'd0, root}));
            if (c < best)
                best = c;
        end
        return best;
    endfunction

    function automatic dist_result_t predict_distance(input logic [LIMIT_W-1:0] lim);
        logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [127:0] dc, abx, aby, cdx, cdy, acx, acy, adx, ady;
        logic signed [127:0] bcx, bcy, bdx, bdy, det, nt, nu, l2;
        logic [OUT_W-1:0]    best, t;
        logic [63:0]         root;
        dist_result_t        r;
        ax = pair_in.a_x; ay = pair_in.a_y; bx = pair_in.b_x; by = pair_in.b_y;
        cx = pair_in.c_x; cy = pair_in.c_y; dx = pair_in.d_x; dy = pair_in.d_y;
        dc = 128'(pair_in.first_dir_x) * 128'(pair_in.second_dir_y)
           - 128'(pair_in.first_dir_y) * 128'(pair_in.second_dir_x);
        if (dc < 0)
            dc = -dc;
        abx = bx - ax; aby = by - ay; cdx = dx - cx; cdy = dy - cy;
        acx = cx - ax; acy = cy - ay; adx = dx - ax; ady = dy - ay;
        bcx = cx - bx; bcy = cy - by; bdx = dx - bx; bdy = dy - by;
        r.crossing = 1'b0;
        // Crossing test only for directions that are not parallel.
        if (dc > $signed({96'd0, lim, 16'd0}))
        begin
            det = cross_of(abx, aby, -cdx, -cdy);
            nt  = cross_of(acx, acy, -cdx, -cdy);
            nu  = cross_of(abx, aby, acx, acy);
            if (det != 0 && in_range(nt, det) && in_range(nu, det))
            begin
                r.seg_distance = '0;
                r.crossing = 1'b1;
                return r;
            end
        end
        // Endpoint to endpoint distances.
        best = clip({64'd0, int_sqrt(acx * acx + acy * acy)});
        t = clip({64'd0, int_sqrt(adx * adx + ady * ady)}); if (t < best) best = t;
        t = clip({64'd0, int_sqrt(bcx * bcx + bcy * bcy)}); if (t < best) best = t;
        t = clip({64'd0, int_sqrt(bdx * bdx + bdy * bdy)}); if (t < best) best = t;
        // Perpendiculars, skipped onto a segment of zero length.
        l2 = abx * abx + aby * aby;
        if (l2 != 0)
        begin
            root = int_sqrt(l2);
            best = foot_dist(best, abx, aby, l2, root, acx, acy);
            best = foot_dist(best, abx, aby, l2, root, adx, ady);
        end
        l2 = cdx * cdx + cdy * cdy;
        if (l2 != 0)
        begin
            root = int_sqrt(l2);
            best = foot_dist(best, cdx, cdy, l2, root, -acx, -acy);
            best = foot_dist(best, cdx, cdy, l2, root, -bcx, -bcy);
        end
        r.seg_distance = best;
        return r;
    endfunction

    assign pending_count = wr_total - rd_total;

    // Track the register and each transfer on both channels.
    always @(posedge clk or negedge rst_n)
    begin
        dist_result_t want;
        if (!rst_n)
        begin
            limit_copy <= '0;
            wr_total <= 0;
            rd_total <= 0;
            error_count <= 0;
        end
        else
        begin
            if (pair_in.valid && pair_in.ready)
            begin
                expected_dists[wr_total[7:0]] <= predict_distance(limit_copy);
                wr_total <= wr_total + 1;
            end
            if (cfg_we)
                limit_copy <= cfg_wdata;
            if (dist_out.valid && dist_out.ready)
            begin
                if (wr_total == rd_total)
                begin
                    $display("%0t: unexpected result dist=%0d crossing=%0b", $time,
                             dist_out.seg_distance, dist_out.crossing);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_dists[rd_total[7:0]];
                    rd_total <= rd_total + 1;
                    if (want.seg_distance !== dist_out.seg_distance
                        || want.crossing !== dist_out.crossing)
                    begin
                        $display("%0t: mismatch expected dist=%0d crossing=%0b,",
                                 $time, want.seg_distance, want.crossing,
                                 " actual dist=%0d crossing=%0b",
                                 dist_out.seg_distance, dist_out.crossing);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives segment pairs through the segment distance block under several
// idling phases and parallel limits; the checker judges every result.
// ============================================================================
module tb;
    import ssd_pkg::*;

    localparam int LATENCY = 80;
    localparam int STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    int                 error_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_receiver;
    bit                 done;
    int                 quiet_cycles;

    ssd_pair_if pair_in ();
    ssd_dist_if dist_out ();

    segment_segment_distance uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair_in  (pair_in),
        .dist_out (dist_out),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    segment_distance_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_in      (pair_in),
        .dist_out     (dist_out),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, or a long hold when asked.
    always @(posedge clk)
    begin
        if (hold_receiver)
            dist_out.ready <= 1'b0;
        else
            dist_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((pair_in.valid && pair_in.ready) || (dist_out.valid && dist_out.ready) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return $signed($urandom());
            1: return $signed($urandom_range(200)) - 100;
            2: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_dir();
        if ($urandom_range(3) == 0)
            return $signed(DIR_W'($urandom()));
        return $signed($urandom_range(131072)) - 65536;
    endfunction

    // Offer one pair and wait for its transfer.
    task automatic send_pair(input logic signed [COORD_W-1:0] c[8],
                             input logic signed [DIR_W-1:0] d[4]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_in.valid <= 1'b0;
            @(posedge clk);
        end
        pair_in.valid <= 1'b1;
        pair_in.a_x <= c[0]; pair_in.a_y <= c[1];
        pair_in.b_x <= c[2]; pair_in.b_y <= c[3];
        pair_in.c_x <= c[4]; pair_in.c_y <= c[5];
        pair_in.d_x <= c[6]; pair_in.d_y <= c[7];
        pair_in.first_dir_x <= d[0]; pair_in.first_dir_y <= d[1];
        pair_in.second_dir_x <= d[2]; pair_in.second_dir_y <= d[3];
        @(posedge clk);
        while (!pair_in.ready)
            @(posedge clk);
    endtask

    // Random pair: often a shared endpoint, a point segment, a parallel copy or a segment CD with midpoint B.
    task automatic send_random_pair();
        logic signed [COORD_W-1:0] c[8];
        logic signed [DIR_W-1:0]   d[4];
        foreach (c[i])
            c[i] = rand_coord();
        foreach (d[i])
            d[i] = rand_dir();
        case ($urandom_range(7))
            0: begin c[4] = c[2]; c[5] = c[3]; end
            1: begin c[2] = c[0]; c[3] = c[1]; end
            2: begin c[6] = c[4] + c[2] - c[0]; c[7] = c[5] + c[3] - c[1]; d[2] = d[0]; d[3] = d[1]; end
            3: begin c[6] = 2 * c[2] - c[4]; c[7] = 2 * c[3] - c[5]; end
            default: ;
        endcase
        send_pair(c, d);
    endtask

    // Let the pipeline drain, then settle before a register write.
    task automatic drain();
        pair_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_directed();
        logic signed [COORD_W-1:0] c[8];
        logic signed [DIR_W-1:0]   d[4];
        // Crossing X through the origin with perpendicular directions.
        c = '{-32'sh10000, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000};
        d = '{18'sh10000, 0, 0, 18'sh10000};
        send_pair(c, d);
        // Same pair with parallel directions: no crossing flag.
        d = '{18'sh10000, 0, 18'sh10000, 0};
        send_pair(c, d);
        // Touching at an endpoint.
        c = '{0, 0, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000};
        d = '{18'sh10000, 0, 0, -18'sh10000};
        send_pair(c, d);
        // Both segments of zero length.
        c = '{5, 5, 5, 5, 100, 100, 100, 100};
        d = '{0, 0, 0, 0};
        send_pair(c, d);
        // Collinear overlapping segments.
        c = '{0, 0, 32'sh40000, 0, 32'sh20000, 0, 32'sh60000, 0};
        d = '{18'sh10000, 0, 18'sh10000, 0};
        send_pair(c, d);
        // Opposite corners at the full coordinate range, and extreme directions.
        c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
        d = '{-18'sh10000, 18'sh10000, 18'sh1ffff, -18'sh20000};
        send_pair(c, d);
        c = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
        d = '{18'sh10000, -18'sh10000, 18'sh10000, 18'sh10000};
        send_pair(c, d);
        // Perpendicular foot inside the other segment.
        c = '{0, 0, 32'sh100000, 0, 32'sh80000, 32'sh30000, 32'sh90000, 32'sh50000};
        d = '{18'sh10000, 0, 18'sh7000, 18'she000};
        send_pair(c, d);
        // Near-parallel lines crossing.
        c = '{0, 0, 32'sh100000, 1, 0, 1, 32'sh100000, 0};
        d = '{18'sh10000, 0, 18'sh10000, -18'sh1};
        send_pair(c, d);
        repeat (12)
            send_random_pair();
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] limits[5];
        limits = '{16'hffff, 16'h0001, 16'h8000, 16'h0000, 16'h0200};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pair_in.valid = 1'b0;
        pair_in.a_x = '0; pair_in.a_y = '0; pair_in.b_x = '0; pair_in.b_y = '0;
        pair_in.c_x = '0; pair_in.c_y = '0; pair_in.d_x = '0; pair_in.d_y = '0;
        pair_in.first_dir_x = '0; pair_in.first_dir_y = '0;
        pair_in.second_dir_x = '0; pair_in.second_dir_y = '0;
        dist_out.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_receiver = 1'b0;
        done = 1'b0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        drain();

        // Phases of idling, each under a different parallel limit.
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            send_idle_pct  = (p == 1 || p == 3) ? 62 : (p == 4 ? 12 : 0);
            recv_stall_pct = (p == 2 || p == 3) ? 62 : (p == 4 ? 12 : 0);
            if (p == 0)
                fork
                    begin
                        hold_receiver = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_receiver = 1'b0;
                    end
                join_none
            for (int i = 0; i < 300; i++)
                send_random_pair();
            drain();
            if (p == 2)
            begin
                send_directed();
                drain();
            end
        end
        drain();

        done = 1'b1;
        if (error_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ssd_pkg.sv
rtl/ssd_pair_if.sv
rtl/ssd_dist_if.sv
rtl/ssd_sqrt.sv
rtl/ssd_div.sv
rtl/segment_segment_distance.sv
test/segment_distance_checker.sv
test/tb.sv
